// ----- src/assert_macros.svh -----
// Assertion macros shared by the location hash modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

// ----- src/ffl_pkg.sv -----
// Types, constants and helper functions for the fuse filter location hash.
`default_nettype none
package ffl_pkg;

    localparam int KEY_W       = 64;
    localparam int NODE_W      = 32;
    localparam int SLOT_W      = 3;
    localparam int ARITY_W     = 4;
    localparam int SEG_COUNT_W = 11;
    localparam int SEG_LEN_W   = 22;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 22;

    localparam int ARITY_LIMIT   = 8;
    localparam int MAX_ARITY_DEF = 8;
    localparam int Q_DEPTH       = 2;

    localparam logic [ARITY_W-1:0]     ARITY_RST     = 4'd3;
    localparam logic [SEG_COUNT_W-1:0] SEG_COUNT_RST = 11'd100;
    localparam logic [SEG_LEN_W-1:0]   SEG_LEN_RST   = 22'd1024;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARITY     = 2'd0,
        CFG_SEG_COUNT = 2'd1,
        CFG_SEG_LEN   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [ARITY_W-1:0]     arity;
        logic [SEG_COUNT_W-1:0] seg_count;
        logic [SEG_LEN_W-1:0]   seg_len;
    } cfg_t;

    // One classified key waiting for the back end; n is the number of locations.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ARITY_W-1:0] n;
    } q_item_t;

    typedef logic [63:0] jump_tab_t [ARITY_LIMIT];

    // Entry i holds the multiplier that advances the generator by i+1 steps.
    function automatic jump_tab_t build_jump_mult();
        jump_tab_t   t;
        logic [63:0] m;
        m = PCG_MULT;
        for (int i = 0; i < ARITY_LIMIT; i++) begin
            t[i] = m;
            m    = m * PCG_MULT;
        end
        return t;
    endfunction

    // Entry i holds the additive term of the same i+1 step jump.
    function automatic jump_tab_t build_jump_add();
        jump_tab_t   t;
        logic [63:0] c;
        c = 64'd1;
        for (int i = 0; i < ARITY_LIMIT; i++) begin
            t[i] = c;
            c    = c * PCG_MULT + 64'd1;
        end
        return t;
    endfunction

    localparam jump_tab_t JUMP_MULT = build_jump_mult();
    localparam jump_tab_t JUMP_ADD  = build_jump_add();

    // Xorshift-high followed by a random rotate of the generator state.
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [4:0]  lrot;
        xs   = 32'(((s >> 18) ^ s) >> 27);
        rot  = s[63:59];
        lrot = 5'd0 - rot;
        return (xs >> rot) | (xs << lrot);
    endfunction

endpackage
`default_nettype wire

// ----- src/ffl_cfg.sv -----
// Configuration register file for arity, segment count and segment length.
`default_nettype none
module ffl_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ffl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffl_pkg::CFG_DATA_W-1:0] cfg_data,
    output ffl_pkg::cfg_t                      cfg
);
    import ffl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ARITY:     cfg_next.arity     = cfg_data[ARITY_W-1:0];
                CFG_SEG_COUNT: cfg_next.seg_count = cfg_data[SEG_COUNT_W-1:0];
                CFG_SEG_LEN:   cfg_next.seg_len   = cfg_data[SEG_LEN_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arity     <= ARITY_RST;
            cfg_reg.seg_count <= SEG_COUNT_RST;
            cfg_reg.seg_len   <= SEG_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/ffl_front.sv -----
// Front end: accepts keys and works out how many locations each one yields.
`default_nettype none
module ffl_front #(
    parameter int MAX_ARITY = ffl_pkg::MAX_ARITY_DEF
) (
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [ffl_pkg::KEY_W-1:0]   key_hash,
    input  wire logic [ffl_pkg::ARITY_W-1:0] arity,
    input  wire logic                       q_full,
    output logic                            push,
    output ffl_pkg::q_item_t                push_item
);
    import ffl_pkg::*;

    localparam logic [ARITY_W-1:0] ArityMax = ARITY_W'(MAX_ARITY);

    logic                accept;
    logic [ARITY_W-1:0]  n_sat;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign n_sat    = (arity > ArityMax) ? ArityMax : arity;

    // A key with no locations is taken and dropped here.
    assign push           = accept && (n_sat != '0);
    assign push_item.key  = key_hash;
    assign push_item.n    = n_sat;

endmodule
`default_nettype wire

// ----- src/ffl_queue.sv -----
// Short queue of classified keys between the front and back ends.
`default_nettype none
`include "assert_macros.svh"
module ffl_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ffl_pkg::q_item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output ffl_pkg::q_item_t      head_item
);
    import ffl_pkg::*;

    localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CntW = $clog2(Q_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Q_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Q_DEPTH);

    q_item_t          entries_reg [Q_DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    assign full       = (count_reg == CntFull);
    assign head_valid = (count_reg != '0);
    assign head_item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_ALWAYS(a_q_count_bound, count_reg <= CntFull, "queue count above depth")
    `ASSERT_IMPLIES(a_q_pop_nonempty, pop, count_reg != '0, "pop from empty queue")
    `ASSERT_IMPLIES(a_q_push_room, push, !full || pop, "push into full queue")

endmodule
`default_nettype wire

// ----- src/ffl_back.sv -----
// Back end: walks the locations of the head key through the generator pipeline.
`default_nettype none
`include "assert_macros.svh"
module ffl_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ffl_pkg::cfg_t               cfg,
    input  wire logic                        head_valid,
    input  wire ffl_pkg::q_item_t            head_item,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [ffl_pkg::NODE_W-1:0]        node_index,
    output logic [ffl_pkg::SLOT_W-1:0]        slot,
    output logic                             last
);
    import ffl_pkg::*;

    logic adv;
    logic tok_last;

    logic [SLOT_W-1:0] slot_cnt_reg, slot_cnt_next;

    // Pipeline valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;

    // Stage 1: partial products of the jump-ahead multiply, first output.
    logic [SLOT_W-1:0] k1_reg;
    logic              last1_reg;
    logic [63:0]       pll1_reg;
    logic [31:0]       plh1_reg, phl1_reg, r0_1_reg;
    // Stage 2: generator state for this slot.
    logic [SLOT_W-1:0] k2_reg;
    logic              last2_reg;
    logic [63:0]       s2_reg;
    logic [31:0]       r0_2_reg;
    // Stage 3: generator output for this slot.
    logic [SLOT_W-1:0] k3_reg;
    logic              last3_reg;
    logic [31:0]       r3_reg, r0_3_reg;
    // Stage 4: scaled offset and start segment.
    logic [SLOT_W-1:0]      k4_reg;
    logic                   last4_reg;
    logic [SEG_LEN_W-1:0]   off4_reg;
    logic [SEG_COUNT_W-1:0] seg4_reg;
    // Stage 5: segment base.
    logic [SLOT_W-1:0]    k5_reg;
    logic                 last5_reg;
    logic [SEG_LEN_W-1:0] off5_reg;
    logic [NODE_W-1:0]    base5_reg;
    // Output register.
    logic [NODE_W-1:0] node_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              last_reg;

    logic [31:0]            a_lo, a_hi, s_lo, s_hi;
    logic [63:0]            s_next;
    logic [53:0]            off_prod;
    logic [42:0]            seg_prod;
    logic [11:0]            seg_k;
    logic [33:0]            base_prod;

    // Everything moves together unless a finished result is held by the sink.
    assign adv      = !out_valid_reg || !out_stall;
    assign tok_last = ({1'b0, slot_cnt_reg} == (head_item.n - 1'b1));
    assign pop      = adv && head_valid && tok_last;

    assign out_valid  = out_valid_reg;
    assign node_index = node_reg;
    assign slot       = slot_reg;
    assign last       = last_reg;

    always_comb
    begin
        slot_cnt_next = slot_cnt_reg;
        if (adv && head_valid)
        begin
            slot_cnt_next = tok_last ? '0 : slot_cnt_reg + 1'b1;
        end
    end

    assign a_lo = JUMP_MULT[slot_cnt_reg][31:0];
    assign a_hi = JUMP_MULT[slot_cnt_reg][63:32];
    assign s_lo = head_item.key[31:0];
    assign s_hi = head_item.key[63:32];

    assign s_next    = pll1_reg + {plh1_reg + phl1_reg, 32'd0} + JUMP_ADD[k1_reg];
    assign off_prod  = 54'(r3_reg) * 54'(cfg.seg_len);
    assign seg_prod  = 43'(r0_3_reg) * 43'(cfg.seg_count);
    assign seg_k     = 12'(seg4_reg) + 12'(k4_reg);
    assign base_prod = 34'(seg_k) * 34'(cfg.seg_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cnt_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_cnt_reg <= slot_cnt_next;
            if (adv)
            begin
                v1_reg        <= head_valid;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                out_valid_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k1_reg    <= slot_cnt_reg;
            last1_reg <= tok_last;
            pll1_reg  <= {32'd0, a_lo} * {32'd0, s_lo};
            plh1_reg  <= a_lo * s_hi;
            phl1_reg  <= a_hi * s_lo;
            r0_1_reg  <= xsh_rr(head_item.key);

            k2_reg    <= k1_reg;
            last2_reg <= last1_reg;
            s2_reg    <= s_next;
            r0_2_reg  <= r0_1_reg;

            k3_reg    <= k2_reg;
            last3_reg <= last2_reg;
            r3_reg    <= xsh_rr(s2_reg);
            r0_3_reg  <= r0_2_reg;

            k4_reg    <= k3_reg;
            last4_reg <= last3_reg;
            off4_reg  <= off_prod[53:32];
            seg4_reg  <= seg_prod[42:32];

            k5_reg    <= k4_reg;
            last5_reg <= last4_reg;
            off5_reg  <= off4_reg;
            base5_reg <= base_prod[NODE_W-1:0];

            node_reg  <= base5_reg + NODE_W'(off5_reg);
            slot_reg  <= k5_reg;
            last_reg  <= last5_reg;
        end
    end

    `ASSERT_IMPLIES(a_back_slot_range, head_valid, {1'b0, slot_cnt_reg} < head_item.n,
        "slot counter beyond key arity")
    `ASSERT_IMPLIES(a_back_last_slot_zero, out_valid_reg && last_reg && slot_reg == '0,
        v5_reg == 1'b0 || k5_reg == '0 || last5_reg == 1'b0,
        "single-location key followed by a stray later slot")

endmodule
`default_nettype wire

// ----- src/fuse_filter_location_hash.sv -----
// Each location passes the key queue, generator stages and output register in turn.
// Throughput: one location per cycle while out_stall is low; a key occupies the
// back end for min(arity, MAX_ARITY) slots in the single jump-ahead generator.
// A key with arity zero is taken and yields nothing.
// Reset empties the key queue and the pipeline and loads arity 3, segment count
// 100 and segment length 1024.
`default_nettype none
module fuse_filter_location_hash #(
    parameter int MAX_ARITY = ffl_pkg::MAX_ARITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ffl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ffl_pkg::KEY_W-1:0]      key_hash,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ffl_pkg::NODE_W-1:0]          node_index,
    output logic [ffl_pkg::SLOT_W-1:0]          slot,
    output logic                               last
);
    import ffl_pkg::*;

    cfg_t    cfg;
    logic    q_full;
    logic    push;
    q_item_t push_item;
    logic    pop;
    logic    head_valid;
    q_item_t head_item;

    ffl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ffl_front #(
        .MAX_ARITY (MAX_ARITY)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key_hash  (key_hash),
        .arity     (cfg.arity),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    ffl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    ffl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .node_index (node_index),
        .slot       (slot),
        .last       (last)
    );

endmodule
`default_nettype wire
